// ===== rtl/core/thzac_pkg.sv =====
// Shared types and constants for the thermal zone aim controller.
package thzac_pkg;

  typedef enum logic [2:0] {
    ACT_PIXEL     = 3'd0,
    ACT_RELAY_ON  = 3'd1,
    ACT_RELAY_OFF = 3'd2,
    ACT_RESUME    = 3'd3,
    ACT_SET_AIM   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    REG_HOT_THRESHOLD = 2'd0,
    REG_AIM_STEP      = 2'd1,
    REG_AIM_MIN       = 2'd2,
    REG_AIM_MAX       = 2'd3
  } reg_index_t;

  // Zone verdict for the pixel currently presented to the frame counter.
  typedef struct packed {
    logic done;
    logic left_win;
    logic middle_win;
    logic right_win;
  } zone_dec_t;

  localparam int LEVEL_W = 12;
  localparam int STEP_W  = 7;
  localparam int ANGLE_W = 8;
  localparam int REQ_W   = 16;
  localparam int CFG_W   = 12;

  localparam logic [ANGLE_W-1:0] AIM_LIMIT = 8'd180;
  localparam logic [ANGLE_W-1:0] AIM_RESET = 8'd15;
  localparam logic signed [LEVEL_W-1:0] HOT_RESET = 12'sd280;
  localparam logic [STEP_W-1:0] STEP_RESET = 7'd10;

endpackage

// ===== rtl/core/thzac_frame.sv =====
// Frame pixel position, column tracking and hot pixel zone counters.
module thzac_frame #(
  parameter int FRAME_PIXELS = 64,
  parameter int ROW_WIDTH    = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   pix_en,
  input  logic signed [thzac_pkg::LEVEL_W-1:0]   pix_level,
  input  logic signed [thzac_pkg::LEVEL_W-1:0]   hot_threshold,
  output thzac_pkg::zone_dec_t                   dec
);

  localparam int POS_W = $clog2(FRAME_PIXELS);
  localparam int COL_W = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int CNT_W = $clog2(FRAME_PIXELS + 1);
  localparam int CX_W  = COL_W + 3;
  localparam logic [CX_W-1:0]  LEFT_LIM = CX_W'(3 * ROW_WIDTH);
  localparam logic [CX_W-1:0]  MID_LIM  = CX_W'(5 * ROW_WIDTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_PIXELS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_WIDTH - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] left_r, middle_r, right_r;
  logic [CNT_W-1:0] left_nxt, middle_nxt, right_nxt;
  logic [CX_W-1:0]  col_x8;
  logic             hot, is_left, is_middle, last;

  assign col_x8    = {col_r, 3'b000};
  assign hot       = pix_level > hot_threshold;
  assign is_left   = col_x8 < LEFT_LIM;
  assign is_middle = !is_left && (col_x8 < MID_LIM);
  assign last      = pos_r == POS_LAST;

  assign left_nxt   = left_r   + CNT_W'(hot && is_left);
  assign middle_nxt = middle_r + CNT_W'(hot && is_middle);
  assign right_nxt  = right_r  + CNT_W'(hot && !is_left && !is_middle);

  always_comb begin
    dec.done       = last;
    dec.left_win   = (left_nxt > middle_nxt) && (left_nxt > right_nxt);
    dec.middle_win = (middle_nxt > left_nxt) && (middle_nxt > right_nxt);
    dec.right_win  = (right_nxt > left_nxt) && (right_nxt > middle_nxt);
  end

  always_comb begin
    pos_nxt = last ? '0 : pos_r + POS_W'(1);
    if (last || col_r == COL_LAST) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      col_r    <= '0;
      left_r   <= '0;
      middle_r <= '0;
      right_r  <= '0;
    end else if (pix_en) begin
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      if (last) begin
        left_r   <= '0;
        middle_r <= '0;
        right_r  <= '0;
      end else begin
        left_r   <= left_nxt;
        middle_r <= middle_nxt;
        right_r  <= right_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/thermal_zone_aim_controller.sv =====
// Thermal zone aim controller: hot pixel zone tracking, aim servo and relay control.
// Takes one item per clock unless a result waits on out_ready: a transfer lands in an
// input register, then a single pass updates the frame counters, aim, relay and sentry
// state and loads the result register, so each item yields one result, and a new item
// may follow before the last one has left. While a result waits, the input register
// still takes one more transfer before in_ready drops. Pixels
// arrive in raster order, FRAME_PIXELS per frame, ROW_WIDTH per row; the last pixel
// of a frame closes it and drives tracking, spraying or sweeping when sentry mode is on.
module thermal_zone_aim_controller #(
  parameter int FRAME_PIXELS = 64,
  parameter int ROW_WIDTH    = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [2:0]                             in_action,
  input  logic signed [thzac_pkg::LEVEL_W-1:0]   in_pixel_level,
  input  logic signed [thzac_pkg::REQ_W-1:0]     in_aim_request,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [thzac_pkg::ANGLE_W-1:0]          out_aim_angle,
  output logic                                   out_relay_level,
  output logic                                   out_spray_pulse,
  output logic                                   out_sentry_active,
  output logic                                   out_frame_done,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [thzac_pkg::CFG_W-1:0]            cfg_data
);

  localparam int AW = thzac_pkg::ANGLE_W;
  localparam int EW = AW + 2;

  // configuration
  logic signed [thzac_pkg::LEVEL_W-1:0] hot_threshold_r;
  logic [thzac_pkg::STEP_W-1:0]         aim_step_r;
  logic [AW-1:0]                        aim_min_r, aim_max_r;

  // input stage
  logic                                 s1_valid_r;
  logic [2:0]                           s1_action_r;
  logic signed [thzac_pkg::LEVEL_W-1:0] s1_level_r;
  logic signed [thzac_pkg::REQ_W-1:0]   s1_req_r;

  // controller state
  logic [AW-1:0] aim_r, aim_nxt;
  logic          sweep_up_r, sweep_up_nxt;
  logic          sentry_r, sentry_nxt;
  logic          relay_r, relay_nxt;
  logic          spray_nxt, done_nxt;

  logic          out_valid_r;
  logic          advance;
  logic          pix_en;
  thzac_pkg::zone_dec_t dec;

  logic [AW-1:0]        lo, hi;
  logic signed [EW-1:0] aim_e, step_e, lo_e, hi_e, moved, sat_lo;
  logic signed [thzac_pkg::REQ_W-1:0] lo_q, hi_q;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign pix_en    = advance && (s1_action_r == thzac_pkg::ACT_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_threshold_r <= thzac_pkg::HOT_RESET;
      aim_step_r      <= thzac_pkg::STEP_RESET;
      aim_min_r       <= '0;
      aim_max_r       <= thzac_pkg::AIM_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        thzac_pkg::REG_HOT_THRESHOLD: hot_threshold_r <= cfg_data;
        thzac_pkg::REG_AIM_STEP:      aim_step_r <= cfg_data[thzac_pkg::STEP_W-1:0];
        thzac_pkg::REG_AIM_MIN:       aim_min_r <= cfg_data[AW-1:0];
        thzac_pkg::REG_AIM_MAX:       aim_max_r <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r <= in_action;
      s1_level_r  <= in_pixel_level;
      s1_req_r    <= in_aim_request;
    end
  end

  thzac_frame #(
    .FRAME_PIXELS(FRAME_PIXELS),
    .ROW_WIDTH   (ROW_WIDTH)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_en       (pix_en),
    .pix_level    (s1_level_r),
    .hot_threshold(hot_threshold_r),
    .dec          (dec)
  );

  // effective limits, capped at the servo range
  assign lo   = (aim_min_r > thzac_pkg::AIM_LIMIT) ? thzac_pkg::AIM_LIMIT : aim_min_r;
  assign hi   = (aim_max_r > thzac_pkg::AIM_LIMIT) ? thzac_pkg::AIM_LIMIT : aim_max_r;
  assign aim_e  = signed'({2'b00, aim_r});
  assign step_e = signed'({3'b000, aim_step_r});
  assign lo_e   = signed'({2'b00, lo});
  assign hi_e   = signed'({2'b00, hi});
  assign lo_q   = signed'({8'h00, lo});
  assign hi_q   = signed'({8'h00, hi});

  always_comb begin
    aim_nxt      = aim_r;
    sweep_up_nxt = sweep_up_r;
    sentry_nxt   = sentry_r;
    relay_nxt    = relay_r;
    spray_nxt    = 1'b0;
    done_nxt     = 1'b0;
    moved        = aim_e;
    sat_lo       = aim_e;
    case (s1_action_r)
      thzac_pkg::ACT_PIXEL: begin
        done_nxt = dec.done;
        if (dec.done && sentry_r) begin
          if (dec.left_win) begin
            moved = aim_e - step_e;
          end else if (dec.middle_win) begin
            spray_nxt = 1'b1;
            relay_nxt = 1'b0;
          end else if (dec.right_win) begin
            moved = aim_e + step_e;
          end else begin
            // tie: sweep, reversing at a limit
            if (aim_e >= hi_e || aim_e <= lo_e) begin
              sweep_up_nxt = !sweep_up_r;
            end
            moved = (aim_e >= hi_e || aim_e <= lo_e) ^ sweep_up_r ?
                    aim_e + step_e : aim_e - step_e;
          end
          sat_lo  = (moved < lo_e) ? lo_e : moved;
          aim_nxt = (sat_lo > hi_e) ? hi : sat_lo[AW-1:0];
        end
      end
      thzac_pkg::ACT_RELAY_ON: begin
        relay_nxt  = 1'b1;
        sentry_nxt = 1'b0;
      end
      thzac_pkg::ACT_RELAY_OFF: begin
        relay_nxt  = 1'b0;
        sentry_nxt = 1'b0;
      end
      thzac_pkg::ACT_RESUME: begin
        sentry_nxt = 1'b1;
      end
      thzac_pkg::ACT_SET_AIM: begin
        if (s1_req_r >= lo_q && s1_req_r <= hi_q) begin
          aim_nxt = s1_req_r[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aim_r       <= thzac_pkg::AIM_RESET;
      sweep_up_r  <= 1'b0;
      sentry_r    <= 1'b1;
      relay_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        aim_r      <= aim_nxt;
        sweep_up_r <= sweep_up_nxt;
        sentry_r   <= sentry_nxt;
        relay_r    <= relay_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_aim_angle     <= aim_nxt;
      out_relay_level   <= relay_nxt;
      out_spray_pulse   <= spray_nxt;
      out_sentry_active <= sentry_nxt;
      out_frame_done    <= done_nxt;
    end
  end

  a_spray_context: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_spray_pulse |->
      out_frame_done && !out_relay_level && out_sentry_active)
    else $error("spray pulse without closed frame in sentry mode");

  a_aim_range: assert property (@(posedge clk) disable iff (!rst_n)
    aim_r <= thzac_pkg::AIM_LIMIT)
    else $error("aim beyond servo range");

  a_cmd_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_action_r != thzac_pkg::ACT_PIXEL) |=> !out_frame_done)
    else $error("command closed a frame");

endmodule
